### hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the pick/launch sequencer
// Field widths, step encodings, valve codes, register indexes and the
// scaled tick counter helpers.
// ----------------------------------------------------------------------------
package pls_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_POWER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_POWER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIND_POWER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_ANGLE_DEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_ANGLE_DEG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLENOID_ON_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HAND_WAIT_MS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE_HZ    = 3'd7;

    // Field widths
    localparam int POWER_W     = 9;
    localparam int ANGLE_W     = 10;
    localparam int MS_W        = 16;
    localparam int RATE_W      = 10;
    localparam int ORDER_W     = 2;
    localparam int ENC_W       = 32;
    localparam int VALVE_W     = 2;
    localparam int TICK_W      = 20;
    localparam int TIME_W      = 30;   // ticks*1000 and ms*rate both fit
    localparam int ANGLE_CMP_W = 42;   // encoder*360 and angle*counts_per_turn

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 10'd100;
    localparam logic [TICK_W-1:0] TICK_MAX        = {TICK_W{1'b1}};
    localparam logic [TIME_W-1:0] TICK_SCALE      = 30'd1000;
    localparam logic [TIME_W-1:0] RELEASE_WAIT_MS = 30'd500;
    localparam logic [TIME_W-1:0] WIND_WAIT_MS    = 30'd1000;

    // Valve command codes
    localparam logic [VALVE_W-1:0] VALVE_NONE = 2'd0;
    localparam logic [VALVE_W-1:0] VALVE_OPEN = 2'd1;
    localparam logic [VALVE_W-1:0] VALVE_HOLD = 2'd2;

    typedef enum logic [2:0] {
        PICK_LOWER     = 3'd1,
        PICK_WAIT_OPEN = 3'd2,
        PICK_GRIP      = 3'd3,
        PICK_WAIT_GRIP = 3'd4,
        PICK_RAISE     = 3'd5,
        PICK_FINISH    = 3'd6
    } pick_step_t;

    typedef enum logic [3:0] {
        LAUNCH_LOWER        = 4'd1,
        LAUNCH_SETTLE       = 4'd2,
        LAUNCH_PULSE        = 4'd3,
        LAUNCH_WAIT_RELEASE = 4'd4,
        LAUNCH_WIND         = 4'd5,
        LAUNCH_RAISE        = 4'd6,
        LAUNCH_UNWIND       = 4'd7,
        LAUNCH_FINISH       = 4'd8
    } launch_step_t;

    // Tick counter kept together with its value times 1000
    typedef struct packed {
        logic [TICK_W-1:0] count;
        logic [TIME_W-1:0] scaled;
    } tick_t;

    // One captured input word, encoder already scaled by 360
    typedef struct packed {
        logic                          order_write;
        logic signed [ORDER_W-1:0]     pick_order;
        logic signed [ORDER_W-1:0]     launch_order;
        logic signed [ORDER_W-1:0]     reverse_order;
        logic                          touch;
        logic signed [ANGLE_CMP_W-1:0] arm_x360;
        logic                          rope_pos;
    } item_t;

    // Settings with all products precomputed
    typedef struct packed {
        logic signed [POWER_W-1:0]     lower_power;
        logic signed [POWER_W-1:0]     raise_power;
        logic signed [POWER_W-1:0]     wind_power;
        logic signed [ANGLE_CMP_W-1:0] lower_thr;
        logic signed [ANGLE_CMP_W-1:0] raise_thr;
        logic [TIME_W-1:0]             hand_thr;
        logic [TIME_W-1:0]             sol_on_thr;
        logic [TIME_W-1:0]             sol_off_thr;
        logic [TIME_W-1:0]             release_thr;
        logic [TIME_W-1:0]             wind_thr;
    } settings_t;

    typedef struct packed {
        pick_step_t                pick_step;
        launch_step_t              launch_step;
        tick_t                     pick_tk;
        tick_t                     launch_tk;
        logic signed [ORDER_W-1:0] pick_req;
        logic signed [ORDER_W-1:0] launch_req;
        logic signed [ORDER_W-1:0] reverse_req;
        logic signed [POWER_W-1:0] arm_cmd;
        logic signed [POWER_W-1:0] winch_cmd;
        logic                      solenoid_cmd;
        logic [VALVE_W-1:0]        valve_cmd;
    } state_t;

    typedef struct packed {
        logic                      launch_done;
        logic                      pick_done;
        logic [VALVE_W-1:0]        valve_mode;
        logic                      solenoid_on;
        logic signed [POWER_W-1:0] winch_power;
        logic signed [POWER_W-1:0] arm_power;
    } result_t;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    // Saturating tick bump
    function automatic tick_t bump_ticks(input tick_t t);
        tick_t r;
        r = t;
        if (t.count != TICK_MAX) begin
            r.count  = t.count + 1'b1;
            r.scaled = t.scaled + TICK_SCALE;
        end
        return r;
    endfunction

    // enc * 360 as shifts: 256 + 64 + 32 + 8
    function automatic logic signed [ANGLE_CMP_W-1:0] times360(
        input logic signed [ENC_W-1:0] enc
    );
        logic signed [ANGLE_CMP_W-1:0] e;
        e = ANGLE_CMP_W'(enc);
        return (e <<< 8) + (e <<< 6) + (e <<< 5) + (e <<< 3);
    endfunction

endpackage

### hdl/pls_step.sv
// ----------------------------------------------------------------------------
// pls_step: one control tick of both sequences
// Combinational next state and result word from the held state, the
// captured input word and the precomputed settings.
// ----------------------------------------------------------------------------
module pls_step (
    input  pls_pkg::state_t    st,
    input  pls_pkg::item_t     item,
    input  pls_pkg::settings_t set,
    output pls_pkg::state_t    nxt,
    output pls_pkg::result_t   res
);

    logic                        pick_done;
    logic                        launch_done;
    pls_pkg::tick_t              tk;
    logic signed [pls_pkg::POWER_W:0] unwind;

    always_comb begin
        nxt         = st;
        pick_done   = 1'b0;
        launch_done = 1'b0;
        tk          = '0;
        unwind      = -{set.wind_power[pls_pkg::POWER_W-1], set.wind_power};

        if (item.order_write) begin
            nxt.pick_req    = item.pick_order;
            nxt.launch_req  = item.launch_order;
            nxt.reverse_req = item.reverse_order;
        end

        // pick sequence runs while its request is positive
        if (!nxt.pick_req[1] && nxt.pick_req[0]) begin
            unique case (st.pick_step)
                pls_pkg::PICK_LOWER: begin
                    nxt.valve_cmd = pls_pkg::VALVE_OPEN;
                    nxt.arm_cmd   = set.lower_power;
                    if (set.lower_thr > item.arm_x360) begin
                        nxt.arm_cmd   = '0;
                        nxt.pick_step = pls_pkg::PICK_WAIT_OPEN;
                    end
                end
                pls_pkg::PICK_WAIT_OPEN, pls_pkg::PICK_WAIT_GRIP: begin
                    tk          = pls_pkg::bump_ticks(st.pick_tk);
                    nxt.pick_tk = tk;
                    if (tk.scaled > set.hand_thr) begin
                        nxt.pick_tk   = '0;
                        nxt.pick_step = (st.pick_step == pls_pkg::PICK_WAIT_OPEN) ?
                                        pls_pkg::PICK_GRIP : pls_pkg::PICK_RAISE;
                    end
                end
                pls_pkg::PICK_GRIP: begin
                    nxt.valve_cmd = pls_pkg::VALVE_HOLD;
                    nxt.pick_step = pls_pkg::PICK_WAIT_GRIP;
                end
                pls_pkg::PICK_RAISE: begin
                    nxt.arm_cmd = set.raise_power;
                    if (set.raise_thr < item.arm_x360) begin
                        nxt.arm_cmd   = '0;
                        nxt.pick_step = pls_pkg::PICK_FINISH;
                    end
                end
                pls_pkg::PICK_FINISH: begin
                    nxt.pick_req  = '0;
                    nxt.pick_step = pls_pkg::PICK_LOWER;
                    pick_done     = 1'b1;
                end
                default: ;
            endcase
        end

        // launch sequence sees the commands left by the pick sequence
        if (!nxt.launch_req[1] && nxt.launch_req[0]) begin
            unique case (st.launch_step)
                pls_pkg::LAUNCH_LOWER: begin
                    nxt.valve_cmd = pls_pkg::VALVE_OPEN;
                    nxt.arm_cmd   = set.lower_power;
                    if (set.lower_thr > item.arm_x360) begin
                        nxt.arm_cmd     = '0;
                        nxt.launch_step = pls_pkg::LAUNCH_SETTLE;
                    end
                end
                pls_pkg::LAUNCH_SETTLE, pls_pkg::LAUNCH_WAIT_RELEASE: begin
                    tk            = pls_pkg::bump_ticks(st.launch_tk);
                    nxt.launch_tk = tk;
                    if (st.launch_step == pls_pkg::LAUNCH_SETTLE) begin
                        if (tk.scaled > set.release_thr) begin
                            nxt.launch_tk   = '0;
                            nxt.launch_step = pls_pkg::LAUNCH_PULSE;
                        end
                    end else if (tk.scaled > set.wind_thr) begin
                        nxt.launch_tk   = '0;
                        nxt.launch_step = pls_pkg::LAUNCH_WIND;
                    end
                end
                pls_pkg::LAUNCH_PULSE: begin
                    // pulse train: on window, then eight times as long off
                    tk = st.launch_tk;
                    if (st.launch_tk.scaled < set.sol_on_thr) begin
                        nxt.solenoid_cmd = 1'b1;
                    end else if (st.launch_tk.scaled < set.sol_off_thr) begin
                        nxt.solenoid_cmd = 1'b0;
                    end else begin
                        tk = '0;
                    end
                    nxt.launch_tk = pls_pkg::bump_ticks(tk);
                    if (item.touch) begin
                        nxt.solenoid_cmd = 1'b0;
                        nxt.launch_tk    = '0;
                        nxt.launch_step  = pls_pkg::LAUNCH_WAIT_RELEASE;
                    end
                end
                pls_pkg::LAUNCH_WIND: begin
                    nxt.winch_cmd = set.wind_power;
                    if (!item.touch) begin
                        nxt.winch_cmd   = '0;
                        nxt.launch_step = pls_pkg::LAUNCH_RAISE;
                    end
                end
                pls_pkg::LAUNCH_RAISE: begin
                    nxt.arm_cmd = set.raise_power;
                    if (set.raise_thr < item.arm_x360) begin
                        nxt.arm_cmd     = '0;
                        nxt.launch_step = pls_pkg::LAUNCH_UNWIND;
                    end
                end
                pls_pkg::LAUNCH_UNWIND: begin
                    // negating -256 saturates to +255
                    nxt.winch_cmd = (!unwind[pls_pkg::POWER_W] && unwind[pls_pkg::POWER_W-1]) ?
                                    9'sd255 : unwind[pls_pkg::POWER_W-1:0];
                    if (item.rope_pos) begin
                        nxt.winch_cmd   = '0;
                        nxt.launch_step = pls_pkg::LAUNCH_FINISH;
                    end
                end
                pls_pkg::LAUNCH_FINISH: begin
                    nxt.launch_req  = '0;
                    nxt.launch_step = pls_pkg::LAUNCH_LOWER;
                    launch_done     = 1'b1;
                end
                default: ;
            endcase
        end

        res.arm_power   = nxt.arm_cmd;
        res.winch_power = nxt.winch_cmd;
        res.solenoid_on = nxt.solenoid_cmd;
        res.valve_mode  = nxt.valve_cmd;
        res.pick_done   = pick_done;
        res.launch_done = launch_done;

        // any stop order drops the commands after they went out
        if (nxt.pick_req[1] || nxt.launch_req[1] || nxt.reverse_req[1]) begin
            nxt.arm_cmd      = '0;
            nxt.winch_cmd    = '0;
            nxt.solenoid_cmd = 1'b0;
            nxt.valve_cmd    = pls_pkg::VALVE_NONE;
        end
    end

endmodule

### hdl/pick_launch_sequencer_top.sv
// ----------------------------------------------------------------------------
// pick_launch_sequencer_top: pick and launch step sequencer
// Stream in control ticks with sensor values and orders, stream out held
// actuator commands and done pulses, one output word per input word.
// ----------------------------------------------------------------------------
// Each input word is one control tick. It is captured into an input register
// (the arm encoder already scaled by 360 on the way in); once the output
// register is free or being read, both sequences advance by one step and the
// result word is loaded into the output register. The block sustains one word
// per cycle while m_tready stays high: the whole sequencer state updates at
// each step, and the input register takes at most one more word while a result
// waits on m_tready. Angle and time thresholds are products of the settings
// that are held in registers and refreshed through the set_reg register after
// a settings write; write settings only while no word is in flight. Order codes: +1 run,
// 0 idle, negative stop. A stopped sequence holds its step and tick count and
// resumes on the next run order.
// ----------------------------------------------------------------------------
module pick_launch_sequencer_top #(
    parameter int COUNTS_PER_TURN = 4048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // settings write port
    input  logic                                cfg_we,
    input  logic [pls_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pls_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // tick words in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pick_order[1:0], launch_order[3:2], reverse_order[5:4], touch[6],
    // arm_encoder[38:7], rope_encoder[70:39], zero pad[71]
    input  logic [pls_pkg::S_DATA_W-1:0]        s_tdata,
    // order_write[0]
    input  logic                                s_tuser,
    // result words out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // arm_power[8:0], winch_power[17:9], solenoid_on[18], valve_mode[20:19],
    // pick_done[21], launch_done[22], zero pad[23]
    output logic [pls_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int CPT_W      = $clog2(COUNTS_PER_TURN + 1);
    localparam int ANG_PROD_W = pls_pkg::ANGLE_W + CPT_W + 1;
    localparam logic signed [ANG_PROD_W-1:0] CPT_S = ANG_PROD_W'(COUNTS_PER_TURN);

    // settings registers
    logic signed [pls_pkg::POWER_W-1:0] lower_power_reg;
    logic signed [pls_pkg::POWER_W-1:0] raise_power_reg;
    logic signed [pls_pkg::POWER_W-1:0] wind_power_reg;
    logic signed [pls_pkg::ANGLE_W-1:0] lower_angle_reg;
    logic signed [pls_pkg::ANGLE_W-1:0] raise_angle_reg;
    logic [pls_pkg::MS_W-1:0]           sol_on_ms_reg;
    logic [pls_pkg::MS_W-1:0]           hand_wait_ms_reg;
    logic [pls_pkg::RATE_W-1:0]         tick_rate_reg;

    pls_pkg::settings_t set_reg;
    pls_pkg::settings_t set_next;

    logic signed [ANG_PROD_W-1:0]                     lower_prod;
    logic signed [ANG_PROD_W-1:0]                     raise_prod;
    logic [pls_pkg::MS_W+pls_pkg::RATE_W-1:0]         hand_prod;
    logic [pls_pkg::MS_W+pls_pkg::RATE_W-1:0]         sol_on_prod;
    logic [pls_pkg::MS_W+3:0]                         sol_off_ms;
    logic [pls_pkg::TIME_W-1:0]                       sol_off_prod;

    // pipeline
    logic             in_valid_reg;
    pls_pkg::item_t   in_item_reg;
    pls_pkg::item_t   in_item_next;
    pls_pkg::state_t  state_reg;
    pls_pkg::state_t  state_next;
    pls_pkg::result_t step_res;
    logic             m_valid_reg;
    pls_pkg::result_t m_res_reg;
    logic             advance;
    logic             s_fire;

    // settings writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_power_reg  <= '0;
            raise_power_reg  <= '0;
            wind_power_reg   <= '0;
            lower_angle_reg  <= '0;
            raise_angle_reg  <= '0;
            sol_on_ms_reg    <= '0;
            hand_wait_ms_reg <= '0;
            tick_rate_reg    <= pls_pkg::TICK_RATE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pls_pkg::CFG_LOWER_POWER:     lower_power_reg  <= cfg_wdata[pls_pkg::POWER_W-1:0];
                pls_pkg::CFG_RAISE_POWER:     raise_power_reg  <= cfg_wdata[pls_pkg::POWER_W-1:0];
                pls_pkg::CFG_WIND_POWER:      wind_power_reg   <= cfg_wdata[pls_pkg::POWER_W-1:0];
                pls_pkg::CFG_LOWER_ANGLE_DEG: lower_angle_reg  <= cfg_wdata[pls_pkg::ANGLE_W-1:0];
                pls_pkg::CFG_RAISE_ANGLE_DEG: raise_angle_reg  <= cfg_wdata[pls_pkg::ANGLE_W-1:0];
                pls_pkg::CFG_SOLENOID_ON_MS:  sol_on_ms_reg    <= cfg_wdata[pls_pkg::MS_W-1:0];
                pls_pkg::CFG_HAND_WAIT_MS:    hand_wait_ms_reg <= cfg_wdata[pls_pkg::MS_W-1:0];
                pls_pkg::CFG_TICK_RATE_HZ:    tick_rate_reg    <= cfg_wdata[pls_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // threshold products, registered so the tick cycle only compares
    always_comb begin
        lower_prod   = ANG_PROD_W'(lower_angle_reg) * CPT_S;
        raise_prod   = ANG_PROD_W'(raise_angle_reg) * CPT_S;
        hand_prod    = hand_wait_ms_reg * tick_rate_reg;
        sol_on_prod  = sol_on_ms_reg * tick_rate_reg;
        sol_off_ms   = ({4'b0, sol_on_ms_reg} << 3) + {4'b0, sol_on_ms_reg};
        sol_off_prod = pls_pkg::TIME_W'(sol_off_ms) * pls_pkg::TIME_W'(tick_rate_reg);

        set_next.lower_power = lower_power_reg;
        set_next.raise_power = raise_power_reg;
        set_next.wind_power  = wind_power_reg;
        set_next.lower_thr   = pls_pkg::ANGLE_CMP_W'(lower_prod);
        set_next.raise_thr   = pls_pkg::ANGLE_CMP_W'(raise_prod);
        set_next.hand_thr    = pls_pkg::TIME_W'(hand_prod);
        set_next.sol_on_thr  = pls_pkg::TIME_W'(sol_on_prod);
        set_next.sol_off_thr = sol_off_prod;
        set_next.release_thr = pls_pkg::TIME_W'(tick_rate_reg) * pls_pkg::RELEASE_WAIT_MS;
        set_next.wind_thr    = pls_pkg::TIME_W'(tick_rate_reg) * pls_pkg::WIND_WAIT_MS;
    end

    always_ff @(posedge aclk) begin
        set_reg <= set_next;
    end

    // handshake: input register refills whenever its word moves on
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_item_next.order_write   = s_tuser;
        in_item_next.pick_order    = s_tdata[1:0];
        in_item_next.launch_order  = s_tdata[3:2];
        in_item_next.reverse_order = s_tdata[5:4];
        in_item_next.touch         = s_tdata[6];
        in_item_next.arm_x360      = pls_pkg::times360(s_tdata[38:7]);
        in_item_next.rope_pos      = !s_tdata[70] && (|s_tdata[69:39]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
    end

    pls_step u_step (
        .st   (state_reg),
        .item (in_item_reg),
        .set  (set_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // sequencer state advances once per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pick_step    <= pls_pkg::PICK_LOWER;
            state_reg.launch_step  <= pls_pkg::LAUNCH_LOWER;
            state_reg.pick_tk      <= '0;
            state_reg.launch_tk    <= '0;
            state_reg.pick_req     <= '0;
            state_reg.launch_req   <= '0;
            state_reg.reverse_req  <= '0;
            state_reg.arm_cmd      <= '0;
            state_reg.winch_cmd    <= '0;
            state_reg.solenoid_cmd <= 1'b0;
            state_reg.valve_cmd    <= pls_pkg::VALVE_NONE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_res_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

endmodule

### tb/sv/tb_pick_launch_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_pick_launch_sequencer_top: self-checking bench for the pick/launch sequencer
// Streams control ticks in and compares every command word that comes out
// against a cycle-free model of both step sequences or a pinned word. A short
// table of directed ticks comes first. Random phases follow, each with its own
// settings and one of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_pick_launch_sequencer_top;

    localparam int CNT_PER_REV    = 4048;   // must match the DUT default
    localparam int DRAIN_PAUSE    = 4;      // pipeline latency plus threshold refresh
    localparam int RX_HOLD_CYCLES = 300;    // long receiver hold-off, fills the pipe
    localparam int STALL_LIMIT    = 4000;   // watchdog: cycles with no handshake
    localparam int PHASE_TICKS    = 50;
    localparam int NUM_PHASES     = 8;
    localparam int SHOW_LIMIT     = 10;

    // Order codes as carried in the 2-bit signed order fields
    localparam logic signed [pls_pkg::ORDER_W-1:0] ORD_IDLE  = 2'sb00;
    localparam logic signed [pls_pkg::ORDER_W-1:0] ORD_RUN   = 2'sb01;
    localparam logic signed [pls_pkg::ORDER_W-1:0] ORD_STOP  = 2'sb11;  // -1
    localparam logic signed [pls_pkg::ORDER_W-1:0] ORD_STOP2 = 2'sb10;  // -2, still a stop

    // One control tick as the bench sees it
    typedef struct packed {
        logic                               order_wr;
        logic signed [pls_pkg::ORDER_W-1:0] pick_ord;
        logic signed [pls_pkg::ORDER_W-1:0] launch_ord;
        logic signed [pls_pkg::ORDER_W-1:0] rev_ord;
        logic                               touch;
        logic signed [pls_pkg::ENC_W-1:0]   arm_enc;
        logic signed [pls_pkg::ENC_W-1:0]   rope_enc;
    } tick_word_t;

    // Directed table row; res is only used where pinned is set
    typedef struct {
        tick_word_t       w;
        bit               pinned;
        pls_pkg::result_t res;
    } dir_row_t;

    // Command words that can be read straight off the sequence description
    localparam pls_pkg::result_t RES_NONE = '0;
    localparam pls_pkg::result_t RES_OPEN = '{launch_done: 1'b0, pick_done: 1'b0,
        valve_mode: pls_pkg::VALVE_OPEN, solenoid_on: 1'b0, winch_power: '0,
        arm_power: '0};
    localparam pls_pkg::result_t RES_HOLD = '{launch_done: 1'b0, pick_done: 1'b0,
        valve_mode: pls_pkg::VALVE_HOLD, solenoid_on: 1'b0, winch_power: '0,
        arm_power: '0};
    localparam pls_pkg::result_t RES_HOLD_PDONE = '{launch_done: 1'b0, pick_done: 1'b1,
        valve_mode: pls_pkg::VALVE_HOLD, solenoid_on: 1'b0, winch_power: '0,
        arm_power: '0};

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [pls_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pls_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [pls_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [pls_pkg::M_DATA_W-1:0]   m_tdata;

    // Pinned expectation travels with the word, so it is sampled at the same edge
    logic             pin_valid = 1'b0;
    pls_pkg::result_t pin_res   = '0;

    // Traffic shaping, set by the stimulus process
    int rx_stall_pct = 0;
    int tx_idle_pct  = 0;
    bit rx_hold_req  = 1'b0;

    // Encoder values near the current angle thresholds
    int lower_center = 0;
    int raise_center = 0;

    // Checking state
    pls_pkg::result_t cmd_words_due[$];
    int               mismatches  = 0;
    int               idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Sequencer model: settings and state
    // ------------------------------------------------------------------------
    logic signed [pls_pkg::POWER_W-1:0] set_lower_pw, set_raise_pw, set_wind_pw;
    logic signed [pls_pkg::ANGLE_W-1:0] set_lower_deg, set_raise_deg;
    logic [pls_pkg::MS_W-1:0]           set_sol_ms, set_hand_ms;
    logic [pls_pkg::RATE_W-1:0]         set_rate;

    pls_pkg::pick_step_t                pk_step;
    pls_pkg::launch_step_t              ln_step;
    logic [pls_pkg::TICK_W-1:0]         pk_ticks, ln_ticks;
    logic signed [pls_pkg::ORDER_W-1:0] pk_req, ln_req, rv_req;
    logic signed [pls_pkg::POWER_W-1:0] arm_q, winch_q;
    logic                               sol_q;
    logic [pls_pkg::VALVE_W-1:0]        valve_q;

    // ------------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------------
    pick_launch_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------
    function automatic logic [pls_pkg::TICK_W-1:0] sat_inc(
        input logic [pls_pkg::TICK_W-1:0] t
    );
        return (t == {pls_pkg::TICK_W{1'b1}}) ? t : t + 1'b1;
    endfunction

    // Exact compare: ticks*1000 > ms*rate
    function automatic bit wait_over(input logic [pls_pkg::TICK_W-1:0] t, input longint ms);
        return longint'(t) * 1000 > ms * longint'(set_rate);
    endfunction

    function automatic bit past_lower(input logic signed [pls_pkg::ENC_W-1:0] enc);
        return longint'(set_lower_deg) * CNT_PER_REV > longint'(enc) * 360;
    endfunction

    function automatic bit past_raise(input logic signed [pls_pkg::ENC_W-1:0] enc);
        return longint'(set_raise_deg) * CNT_PER_REV < longint'(enc) * 360;
    endfunction

    task automatic reset_model();
        set_lower_pw  = '0;
        set_raise_pw  = '0;
        set_wind_pw   = '0;
        set_lower_deg = '0;
        set_raise_deg = '0;
        set_sol_ms    = '0;
        set_hand_ms   = '0;
        set_rate      = pls_pkg::TICK_RATE_RESET;
        pk_step  = pls_pkg::PICK_LOWER;
        ln_step  = pls_pkg::LAUNCH_LOWER;
        pk_ticks = '0;
        ln_ticks = '0;
        pk_req   = ORD_IDLE;
        ln_req   = ORD_IDLE;
        rv_req   = ORD_IDLE;
        arm_q    = '0;
        winch_q  = '0;
        sol_q    = 1'b0;
        valve_q  = pls_pkg::VALVE_NONE;
    endtask

    task automatic apply_setting(input logic [pls_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [pls_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            pls_pkg::CFG_LOWER_POWER:     set_lower_pw  = val[pls_pkg::POWER_W-1:0];
            pls_pkg::CFG_RAISE_POWER:     set_raise_pw  = val[pls_pkg::POWER_W-1:0];
            pls_pkg::CFG_WIND_POWER:      set_wind_pw   = val[pls_pkg::POWER_W-1:0];
            pls_pkg::CFG_LOWER_ANGLE_DEG: set_lower_deg = val[pls_pkg::ANGLE_W-1:0];
            pls_pkg::CFG_RAISE_ANGLE_DEG: set_raise_deg = val[pls_pkg::ANGLE_W-1:0];
            pls_pkg::CFG_SOLENOID_ON_MS:  set_sol_ms    = val[pls_pkg::MS_W-1:0];
            pls_pkg::CFG_HAND_WAIT_MS:    set_hand_ms   = val[pls_pkg::MS_W-1:0];
            pls_pkg::CFG_TICK_RATE_HZ:    set_rate      = val[pls_pkg::RATE_W-1:0];
            default: ;
        endcase
    endtask

    // Advance both sequences by one tick and return the command word it emits
    function automatic pls_pkg::result_t step_sequencer(input tick_word_t w);
        pls_pkg::result_t r;
        logic             pdone;
        logic             ldone;
        longint           tt;
        longint           unwind;
        pdone = 1'b0;
        ldone = 1'b0;
        if (w.order_wr) begin
            pk_req = w.pick_ord;
            ln_req = w.launch_ord;
            rv_req = w.rev_ord;
        end

        if (pk_req > 0) begin
            case (pk_step)
                pls_pkg::PICK_LOWER: begin
                    valve_q = pls_pkg::VALVE_OPEN;
                    arm_q   = set_lower_pw;
                    if (past_lower(w.arm_enc)) begin
                        arm_q   = '0;
                        pk_step = pls_pkg::PICK_WAIT_OPEN;
                    end
                end
                pls_pkg::PICK_WAIT_OPEN, pls_pkg::PICK_WAIT_GRIP: begin
                    pk_ticks = sat_inc(pk_ticks);
                    if (wait_over(pk_ticks, longint'(set_hand_ms))) begin
                        pk_step  = (pk_step == pls_pkg::PICK_WAIT_OPEN) ?
                                   pls_pkg::PICK_GRIP : pls_pkg::PICK_RAISE;
                        pk_ticks = '0;
                    end
                end
                pls_pkg::PICK_GRIP: begin
                    valve_q = pls_pkg::VALVE_HOLD;
                    pk_step = pls_pkg::PICK_WAIT_GRIP;
                end
                pls_pkg::PICK_RAISE: begin
                    arm_q = set_raise_pw;
                    if (past_raise(w.arm_enc)) begin
                        arm_q   = '0;
                        pk_step = pls_pkg::PICK_FINISH;
                    end
                end
                pls_pkg::PICK_FINISH: begin
                    pk_req  = ORD_IDLE;
                    pk_step = pls_pkg::PICK_LOWER;
                    pdone   = 1'b1;
                end
                default: ;
            endcase
        end

        if (ln_req > 0) begin
            case (ln_step)
                pls_pkg::LAUNCH_LOWER: begin
                    valve_q = pls_pkg::VALVE_OPEN;
                    arm_q   = set_lower_pw;
                    if (past_lower(w.arm_enc)) begin
                        arm_q   = '0;
                        ln_step = pls_pkg::LAUNCH_SETTLE;
                    end
                end
                pls_pkg::LAUNCH_SETTLE: begin
                    ln_ticks = sat_inc(ln_ticks);
                    if (wait_over(ln_ticks, 500)) begin
                        ln_step  = pls_pkg::LAUNCH_PULSE;
                        ln_ticks = '0;
                    end
                end
                pls_pkg::LAUNCH_PULSE: begin
                    // on for sol_ms, off for 8x that, then the window restarts
                    tt = longint'(ln_ticks) * 1000;
                    if (tt < longint'(set_sol_ms) * longint'(set_rate))
                        sol_q = 1'b1;
                    else if (tt < longint'(set_sol_ms) * 9 * longint'(set_rate))
                        sol_q = 1'b0;
                    else
                        ln_ticks = '0;
                    ln_ticks = sat_inc(ln_ticks);
                    if (w.touch) begin
                        sol_q    = 1'b0;
                        ln_step  = pls_pkg::LAUNCH_WAIT_RELEASE;
                        ln_ticks = '0;
                    end
                end
                pls_pkg::LAUNCH_WAIT_RELEASE: begin
                    ln_ticks = sat_inc(ln_ticks);
                    if (wait_over(ln_ticks, 1000)) begin
                        ln_step  = pls_pkg::LAUNCH_WIND;
                        ln_ticks = '0;
                    end
                end
                pls_pkg::LAUNCH_WIND: begin
                    winch_q = set_wind_pw;
                    if (!w.touch) begin
                        winch_q = '0;
                        ln_step = pls_pkg::LAUNCH_RAISE;
                    end
                end
                pls_pkg::LAUNCH_RAISE: begin
                    arm_q = set_raise_pw;
                    if (past_raise(w.arm_enc)) begin
                        arm_q   = '0;
                        ln_step = pls_pkg::LAUNCH_UNWIND;
                    end
                end
                pls_pkg::LAUNCH_UNWIND: begin
                    // -(-256) does not fit, clamp to +255
                    unwind = -longint'(set_wind_pw);
                    if (unwind > 255)
                        unwind = 255;
                    winch_q = unwind[pls_pkg::POWER_W-1:0];
                    if (w.rope_enc > 0) begin
                        winch_q = '0;
                        ln_step = pls_pkg::LAUNCH_FINISH;
                    end
                end
                pls_pkg::LAUNCH_FINISH: begin
                    ln_req  = ORD_IDLE;
                    ln_step = pls_pkg::LAUNCH_LOWER;
                    ldone   = 1'b1;
                end
                default: ;
            endcase
        end

        r.arm_power   = arm_q;
        r.winch_power = winch_q;
        r.solenoid_on = sol_q;
        r.valve_mode  = valve_q;
        r.pick_done   = pdone;
        r.launch_done = ldone;

        // any stop clears the held commands after they went out
        if (pk_req < 0 || ln_req < 0 || rv_req < 0) begin
            arm_q   = '0;
            winch_q = '0;
            sol_q   = 1'b0;
            valve_q = pls_pkg::VALVE_NONE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predicts on input words, checks output words, watchdog
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input pls_pkg::result_t want,
                                   input pls_pkg::result_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display({"[%0t] %s: exp arm=%0d winch=%0d sol=%0d valve=%0d pd=%0d ld=%0d",
                      " | got arm=%0d winch=%0d sol=%0d valve=%0d pd=%0d ld=%0d"},
                $time, what, want.arm_power, want.winch_power, want.solenoid_on,
                want.valve_mode, want.pick_done, want.launch_done,
                got.arm_power, got.winch_power, got.solenoid_on,
                got.valve_mode, got.pick_done, got.launch_done);
    endtask

    always @(posedge aclk) begin : scoreboard
        pls_pkg::result_t got;
        pls_pkg::result_t want;
        tick_word_t       w;
        if (!aresetn) begin
            reset_model();
            idle_cycles = 0;
        end else begin
            // check first: a word accepted at this edge cannot have its result yet
            if (m_tvalid && m_tready) begin
                got = pls_pkg::result_t'(m_tdata[$bits(pls_pkg::result_t)-1:0]);
                if (cmd_words_due.size() == 0) begin
                    report_mismatch("unexpected word", RES_NONE, got);
                end else begin
                    want = cmd_words_due.pop_front();
                    if (got.arm_power !== want.arm_power ||
                        got.winch_power !== want.winch_power ||
                        got.solenoid_on !== want.solenoid_on ||
                        got.valve_mode !== want.valve_mode ||
                        got.pick_done !== want.pick_done ||
                        got.launch_done !== want.launch_done)
                        report_mismatch("command word", want, got);
                end
            end

            if (cfg_we)
                apply_setting(cfg_index, cfg_wdata);

            if (s_tvalid && s_tready) begin
                w.order_wr   = s_tuser;
                w.pick_ord   = s_tdata[1:0];
                w.launch_ord = s_tdata[3:2];
                w.rev_ord    = s_tdata[5:4];
                w.touch      = s_tdata[6];
                w.arm_enc    = s_tdata[38:7];
                w.rope_enc   = s_tdata[70:39];
                want = step_sequencer(w);
                cmd_words_due.push_back(pin_valid ? pin_res : want);
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("pick_launch_sequencer_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offer one word, with random gaps ahead of it; returns at the accepting edge
    task automatic push_tick(input tick_word_t w, input bit pinned,
                             input pls_pkg::result_t res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= w.order_wr;
        s_tdata   <= {1'b0, w.rope_enc, w.arm_enc, w.touch,
                      w.rev_ord, w.launch_ord, w.pick_ord};
        pin_valid <= pinned;
        pin_res   <= res;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Run orders at the given percentage, the rest mostly idle, a few stops of both codes
    function automatic logic signed [pls_pkg::ORDER_W-1:0] pick_order_code(
        input int run_pct
    );
        int r;
        r = $urandom_range(0, 99);
        if (r < run_pct)
            return ORD_RUN;
        else if (r < 85)
            return ORD_IDLE;
        else if (r < 93)
            return ORD_STOP;
        return ORD_STOP2;
    endfunction

    // Tidy ticks keep orders mostly running and sensors near the thresholds so
    // the sequences get deep; the rest is noise over the full field ranges.
    function automatic tick_word_t random_tick(input bit tidy);
        tick_word_t w;
        int         ctr;
        if (tidy) begin
            w.order_wr   = ($urandom_range(0, 99) < 12);
            w.pick_ord   = pick_order_code(60);
            w.launch_ord = pick_order_code(60);
            w.rev_ord    = ($urandom_range(0, 99) < 85) ? ORD_IDLE : pick_order_code(30);
            w.touch      = ($urandom_range(0, 99) < 30);
            ctr          = $urandom_range(0, 1) ? lower_center : raise_center;
            w.arm_enc    = ctr + int'($urandom_range(0, 80)) - 40;
            w.rope_enc   = int'($urandom_range(0, 40)) - 20;
        end else begin
            w.order_wr   = 1'($urandom_range(0, 1));
            w.pick_ord   = 2'($urandom_range(0, 3));
            w.launch_ord = 2'($urandom_range(0, 3));
            w.rev_ord    = 2'($urandom_range(0, 3));
            w.touch      = 1'($urandom_range(0, 1));
            w.arm_enc    = $urandom();
            w.rope_enc   = $urandom();
        end
        return w;
    endfunction

    // Wait for the pipe to drain, then write every register once
    task automatic program_settings(input int lp, input int rp, input int wp,
                                    input int la, input int ra, input int son,
                                    input int hw, input int rate);
        logic [pls_pkg::CFG_DATA_W-1:0] vals [8];
        logic [pls_pkg::CFG_IDX_W-1:0]  idxs [8];
        vals = '{pls_pkg::CFG_DATA_W'(lp), pls_pkg::CFG_DATA_W'(rp),
                 pls_pkg::CFG_DATA_W'(wp), pls_pkg::CFG_DATA_W'(la),
                 pls_pkg::CFG_DATA_W'(ra), pls_pkg::CFG_DATA_W'(son),
                 pls_pkg::CFG_DATA_W'(hw), pls_pkg::CFG_DATA_W'(rate)};
        idxs = '{pls_pkg::CFG_LOWER_POWER, pls_pkg::CFG_RAISE_POWER,
                 pls_pkg::CFG_WIND_POWER, pls_pkg::CFG_LOWER_ANGLE_DEG,
                 pls_pkg::CFG_RAISE_ANGLE_DEG, pls_pkg::CFG_SOLENOID_ON_MS,
                 pls_pkg::CFG_HAND_WAIT_MS, pls_pkg::CFG_TICK_RATE_HZ};
        s_tvalid <= 1'b0;
        while (cmd_words_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        lower_center = (la * CNT_PER_REV) / 360;
        raise_center = (ra * CNT_PER_REV) / 360;
    endtask

    // ------------------------------------------------------------------------
    // Directed ticks, run with the reset settings (all zero, 100 Hz).
    // Pinned rows walk a full pick with zero thresholds, start a launch,
    // stop it with the -2 code, then check that stops clear the commands
    // after emission and that a stopped launch resumes where it was held.
    // ------------------------------------------------------------------------
    dir_row_t dir_rows [18] = '{
        // idle tick right after reset
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b0, 32'sd0, 32'sd0}, 1'b1, RES_NONE},
        // pick: open and lower, already past the zero angle
        '{'{1'b1, ORD_RUN, ORD_IDLE, ORD_IDLE, 1'b0, -32'sd1, 32'sd0}, 1'b1, RES_OPEN},
        // zero wait is over after one tick; encoder extremes
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b0, 32'sh7FFFFFFF, 32'sh80000000},
          1'b1, RES_OPEN},
        // grip
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b1, 32'sd0, -32'sd1}, 1'b1, RES_HOLD},
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b0, 32'sh55555555, 32'sh2AAAAAAA},
          1'b1, RES_HOLD},
        // raise ends once the encoder is above zero
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b0, 32'sd1, 32'sd0}, 1'b1, RES_HOLD},
        // finishing step: done pulse, request drops
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b0, 32'sd0, 32'sd0}, 1'b1, RES_HOLD_PDONE},
        // launch: open and lower
        '{'{1'b1, ORD_IDLE, ORD_RUN, ORD_IDLE, 1'b0, 32'sh80000000, 32'sd0}, 1'b1, RES_OPEN},
        // -2 stops: held commands go out once more, then clear
        '{'{1'b1, ORD_IDLE, ORD_STOP2, ORD_IDLE, 1'b0, 32'sd0, 32'sd0}, 1'b1, RES_OPEN},
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b0, 32'sd0, 32'sd0}, 1'b1, RES_NONE},
        // reverse stop alone also clears after emission
        '{'{1'b1, ORD_RUN, ORD_IDLE, ORD_STOP, 1'b0, 32'sd0, 32'sd0}, 1'b1, RES_OPEN},
        // launch resumes at its held settle step, nothing driven yet
        '{'{1'b1, ORD_STOP, ORD_RUN, ORD_RUN, 1'b0, 32'sd0, 32'sd0}, 1'b1, RES_NONE},
        // predictor-checked from here on
        '{'{1'b1, ORD_RUN, ORD_RUN, ORD_IDLE, 1'b1, -32'sd5, 32'sd5}, 1'b0, RES_NONE},
        '{'{1'b1, ORD_STOP2, ORD_STOP2, ORD_STOP2, 1'b1, 32'shAAAAAAAA, 32'sh55555555},
          1'b0, RES_NONE},
        '{'{1'b1, ORD_RUN, ORD_RUN, ORD_IDLE, 1'b0, 32'shFFFFFFFF, 32'shFFFFFFFF},
          1'b0, RES_NONE},
        '{'{1'b0, ORD_IDLE, ORD_IDLE, ORD_IDLE, 1'b1, 32'sh0000FFFF, 32'shFFFF0000},
          1'b0, RES_NONE},
        '{'{1'b1, ORD_RUN, ORD_STOP, ORD_IDLE, 1'b0, 32'sd12, -32'sd12}, 1'b0, RES_NONE},
        '{'{1'b1, ORD_RUN, ORD_RUN, ORD_RUN, 1'b1, 32'sd100, 32'sd1}, 1'b0, RES_NONE}
    };

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            push_tick(dir_rows[i].w, dir_rows[i].pinned, dir_rows[i].res);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // settings per phase; extremes first
            case (ph)
                0: program_settings(255, -255, -256, 360, -360, 0, 0, 1);
                1: program_settings(-256, 255, 255, -512, 511, 65535, 65535, 1);
                3: program_settings(int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 720)) - 360,
                                    int'($urandom_range(0, 720)) - 360,
                                    $urandom_range(0, 2), $urandom_range(0, 3), 1000);
                5: program_settings(int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 510)) - 255,
                                    -256, 0, 0, 1, 2, 1023);
                7: program_settings(int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 510)) - 255,
                                    int'($urandom_range(0, 720)) - 360,
                                    int'($urandom_range(0, 720)) - 360,
                                    $urandom_range(0, 100), $urandom_range(0, 400), 0);
                default:
                    program_settings(int'($urandom_range(0, 510)) - 255,
                                     int'($urandom_range(0, 510)) - 255,
                                     int'($urandom_range(0, 510)) - 255,
                                     int'($urandom_range(0, 720)) - 360,
                                     int'($urandom_range(0, 720)) - 360,
                                     $urandom_range(0, 100), $urandom_range(0, 400),
                                     $urandom_range(1, 20));
            endcase

            // gap mix: none, sender only, receiver only, both
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase

            // back-pressure: receiver holds off while words keep coming
            if (ph == 0)
                rx_hold_req = 1'b1;

            repeat (PHASE_TICKS)
                push_tick(random_tick($urandom_range(0, 99) < 80), 1'b0, RES_NONE);
        end

        s_tvalid <= 1'b0;
        while (cmd_words_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && cmd_words_due.size() == 0)
            $display("pick_launch_sequencer_top: match");
        else
            $display("pick_launch_sequencer_top: mismatch");
        $finish;
    end

endmodule
